@@ hdl/wdd_pkg.sv @@
package wdd_pkg;

  localparam int X_W        = 12;
  localparam int Y_W        = 12;
  localparam int FRAC_W     = 8;
  localparam int YPOS_W     = Y_W + FRAC_W;
  localparam int CFG_N_W    = 17;
  localparam int CFG_W_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

  localparam logic CMD_MOVE = 1'b0;
  localparam logic CMD_LINE = 1'b1;

  typedef enum logic [1:0] {
    MODE_PASS   = 2'd0,
    MODE_MEAN   = 2'd1,
    MODE_MINMAX = 2'd2
  } mode_t;

  typedef struct packed {
    logic              command;
    logic [X_W-1:0]    x_pos;
    logic [YPOS_W-1:0] y_pos;
  } res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hdl/wdd_if.sv @@
interface wdd_in_if;
  import wdd_pkg::*;

  logic           valid;
  logic           ready;
  logic [X_W-1:0] x_pixel;
  logic [Y_W-1:0] y_pixel;

  modport source (output valid, x_pixel, y_pixel, input ready);
  modport sink   (input valid, x_pixel, y_pixel, output ready);
endinterface

interface wdd_out_if;
  import wdd_pkg::*;

  logic              valid;
  logic              ready;
  logic              command;
  logic [X_W-1:0]    x_pos;
  logic [YPOS_W-1:0] y_pos;
  logic              last;

  modport source (output valid, command, x_pos, y_pos, last, input ready);
  modport sink   (input valid, command, x_pos, y_pos, last, output ready);
endinterface

@@ hdl/wdd_divider.sv @@
module wdd_divider #(
  parameter int DVW = 25,
  parameter int DSW = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVW-1:0]      dividend,
  input  logic [DSW-1:0]      divisor,
  output logic [DVW-1:0]      quotient,
  output logic [DSW-1:0]      remainder,
  output wdd_pkg::div_stat_t  stat
);
  import wdd_pkg::*;

  localparam int CNTW = $clog2(DVW + 1);

  logic [DVW-1:0]  quo_r, quo_nxt;
  logic [DSW-1:0]  rem_r, rem_nxt;
  logic [DSW-1:0]  dvs_r, dvs_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            done_r, done_nxt;
  logic [DSW:0]    shifted;
  logic [DSW:0]    diff;
  logic            ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted  = {rem_r, quo_r[DVW-1]};
    diff     = shifted - {1'b0, dvs_r};
    ge       = shifted >= {1'b0, dvs_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
      cnt_nxt = CNTW'(DVW);
    end else if (cnt_r != '0) begin
      quo_nxt  = {quo_r[DVW-2:0], ge};
      rem_nxt  = ge ? diff[DSW-1:0] : shifted[DSW-1:0];
      cnt_nxt  = cnt_r - CNTW'(1);
      done_nxt = (cnt_r == CNTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient  = quo_r;
  assign remainder = rem_r;
  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;

endmodule

@@ hdl/waveform_display_decimator.sv @@
// Channel  Dir  Transaction                               Payload
// in_ch    in   one plotted point                         x_pixel, y_pixel
// out_ch   out  one path command (0..2 per point)         command, x_pos, y_pos, last
// cfg_*    in   register write, index 0 points, 1 columns  cfg_index, cfg_data
//
// A point is taken (S_IDLE), evaluated (S_EVAL) and then each command is offered
// (S_EMIT); a min/max column close adds a range-start update (S_ADV, S_ADV2),
// none when it ends the frame. A mean column close adds a division on the shared
// restoring divider, one quotient bit per cycle, then the range-start update.
// After reset and after each config write, two divisions on the same divider
// run before in_ch.ready rises.
// Reset is synchronous, active low. Commands hold until out_ch.ready; no point
// is taken until all commands of the previous one are delivered.
module waveform_display_decimator #(
  parameter int MAX_POINTS  = 65536,
  parameter int MAX_COLUMNS = 4096,
  parameter int MEAN_STRIDE = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  wdd_in_if.sink                            in_ch,
  wdd_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [wdd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wdd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import wdd_pkg::*;

  localparam int NW   = CFG_N_W;
  localparam int WW   = CFG_W_W;
  localparam int SW   = $clog2(MEAN_STRIDE + 1);
  localparam int PW   = NW + SW;
  localparam int SUMW = $clog2((2 * MEAN_STRIDE - 1) * ((1 << Y_W) - 1) + 1);
  localparam int DVW  = (PW > SUMW + FRAC_W) ? PW : SUMW + FRAC_W;
  localparam int RW   = NW + 1;
  localparam int CW   = $clog2((1 << WW) + MEAN_STRIDE);

  typedef enum logic [10:0] {
    S_SETQ   = 11'b000_0000_0001,
    S_WAITQ  = 11'b000_0000_0010,
    S_SETP   = 11'b000_0000_0100,
    S_WAITP  = 11'b000_0000_1000,
    S_IDLE   = 11'b000_0001_0000,
    S_EVAL   = 11'b000_0010_0000,
    S_MEANGO = 11'b000_0100_0000,
    S_MEANW  = 11'b000_1000_0000,
    S_ADV    = 11'b001_0000_0000,
    S_ADV2   = 11'b010_0000_0000,
    S_EMIT   = 11'b100_0000_0000
  } state_t;

  state_t          state_r, state_nxt;
  logic [NW-1:0]   total_points_r, total_points_nxt;
  logic [WW-1:0]   column_count_r, column_count_nxt;

  logic [NW-1:0]   q_r, q_nxt;
  logic [WW-1:0]   r_r, r_nxt;
  logic [PW-1:0]   p_r, p_nxt;
  logic [WW-1:0]   pr_r, pr_nxt;
  mode_t           mode_r, mode_nxt;

  logic [NW-1:0]   s_r, s_nxt;
  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   rs_r, rs_nxt;
  logic [RW-1:0]   re_r, re_nxt;
  logic [WW-1:0]   rem_r, rem_nxt;
  logic [Y_W-1:0]  min_r, min_nxt;
  logic [Y_W-1:0]  max_r, max_nxt;
  logic [SUMW-1:0] sum_r, sum_nxt;
  logic            stopped_r, stopped_nxt;

  logic [X_W-1:0]  x_r, x_nxt;
  logic [Y_W-1:0]  y_r, y_nxt;
  res_t            res_r [2];
  res_t            res_nxt [2];
  logic [1:0]      res_cnt_r, res_cnt_nxt;
  logic            res_idx_r, res_idx_nxt;
  logic            mean_slot_r, mean_slot_nxt;

  logic [NW-1:0]   n_eff;
  logic [WW-1:0]   w_eff;
  logic [PW-1:0]   n_stride;
  mode_t           mode_new;
  logic [RW-1:0]   len_cur;
  logic [NW-1:0]   s_inc;
  logic            frame_end;
  logic            in_range;
  logic            range_last;
  logic            mean_stop;
  logic            mean_hit;
  logic [SUMW-1:0] sum_add;
  logic [Y_W-1:0]  min_new;
  logic [Y_W-1:0]  max_new;
  logic [YPOS_W-1:0] y_shift;
  logic [WW-1:0]   step_rem;
  logic [WW:0]     rem_sum;
  logic            rem_carry;
  logic [1:0]      slot_k;
  logic            mean_go;
  logic            adv_go;
  logic            clr;
  logic [RW-1:0]   clr_len;
  logic            in_acc;
  logic            out_acc;
  logic            out_last;

  logic              div_start;
  logic [DVW-1:0]    div_dividend;
  logic [WW-1:0]     div_divisor;
  logic [DVW-1:0]    div_quo;
  logic [WW-1:0]     div_rem;
  div_stat_t         div_stat;

  wdd_divider #(
    .DVW (DVW),
    .DSW (WW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  // effective register values
  always_comb begin
    if (total_points_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(total_points_r) > MAX_POINTS) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = total_points_r;
    end
    if (column_count_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(column_count_r) > MAX_COLUMNS) begin
      w_eff = WW'(MAX_COLUMNS);
    end else begin
      w_eff = column_count_r;
    end
  end

  assign n_stride = PW'(n_eff) * PW'(MEAN_STRIDE);

  always_comb begin
    priority if (32'(n_eff) <= 32'(w_eff)) begin
      mode_new = MODE_PASS;
    end else if (32'(n_eff) < (32'(w_eff) << 1)) begin
      mode_new = MODE_MEAN;
    end else begin
      mode_new = MODE_MINMAX;
    end
  end

  assign div_start = (state_r == S_SETQ) || (state_r == S_SETP) || (state_r == S_MEANGO);

  always_comb begin
    priority if (state_r == S_MEANGO) begin
      div_dividend = DVW'({sum_r, {FRAC_W{1'b0}}});
      div_divisor  = WW'(p_r);
    end else if (state_r == S_SETP) begin
      div_dividend = DVW'(n_stride);
      div_divisor  = w_eff;
    end else begin
      div_dividend = DVW'(n_eff);
      div_divisor  = w_eff;
    end
  end

  assign len_cur    = (mode_r == MODE_MEAN) ? RW'(p_r) : RW'(q_r);
  assign s_inc      = s_r + NW'(1);
  assign frame_end  = s_inc >= n_eff;
  assign in_range   = (RW'(s_r) >= rs_r) && (RW'(s_r) < re_r);
  assign range_last = (RW'(s_inc) == re_r);
  assign mean_stop  = stopped_r || (32'(col_r) >= 32'(w_eff)) || (re_r >= RW'(n_eff));
  assign mean_hit   = !mean_stop && in_range;
  assign sum_add    = sum_r + SUMW'(y_r);
  assign min_new    = (y_r < min_r) ? y_r : min_r;
  assign max_new    = (y_r > max_r) ? y_r : max_r;
  assign y_shift    = {y_r, {FRAC_W{1'b0}}};

  // range start advance: column*N = range_start*W + remainder
  assign step_rem   = (mode_r == MODE_MEAN) ? pr_r : r_r;
  assign rem_sum    = {1'b0, rem_r} + {1'b0, step_rem};
  assign rem_carry  = rem_sum >= {1'b0, w_eff};

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign out_last = ({1'b0, res_idx_r} == res_cnt_r - 2'd1);

  always_comb begin
    state_nxt        = state_r;
    total_points_nxt = total_points_r;
    column_count_nxt = column_count_r;
    q_nxt            = q_r;
    r_nxt            = r_r;
    p_nxt            = p_r;
    pr_nxt           = pr_r;
    mode_nxt         = mode_r;
    s_nxt            = s_r;
    col_nxt          = col_r;
    rs_nxt           = rs_r;
    re_nxt           = re_r;
    rem_nxt          = rem_r;
    min_nxt          = min_r;
    max_nxt          = max_r;
    sum_nxt          = sum_r;
    stopped_nxt      = stopped_r;
    x_nxt            = x_r;
    y_nxt            = y_r;
    res_nxt          = res_r;
    res_cnt_nxt      = res_cnt_r;
    res_idx_nxt      = res_idx_r;
    mean_slot_nxt    = mean_slot_r;
    slot_k           = 2'd0;
    mean_go          = 1'b0;
    adv_go           = 1'b0;
    clr              = 1'b0;
    clr_len          = len_cur;

    unique case (state_r)
      S_SETQ: begin
        state_nxt = S_WAITQ;
      end
      S_WAITQ: begin
        if (div_stat.done) begin
          q_nxt     = NW'(div_quo);
          r_nxt     = div_rem;
          state_nxt = S_SETP;
        end
      end
      S_SETP: begin
        state_nxt = S_WAITP;
      end
      S_WAITP: begin
        if (div_stat.done) begin
          p_nxt     = PW'(div_quo);
          pr_nxt    = div_rem;
          mode_nxt  = mode_new;
          clr       = 1'b1;
          clr_len   = (mode_new == MODE_MEAN) ? RW'(div_quo) : RW'(q_r);
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          x_nxt     = in_ch.x_pixel;
          y_nxt     = in_ch.y_pixel;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        s_nxt       = s_inc;
        res_idx_nxt = 1'b0;
        unique case (mode_r)
          MODE_PASS: begin
            res_nxt[0] = '{(s_r == '0) ? CMD_MOVE : CMD_LINE, x_r, y_shift};
            slot_k     = 2'd1;
          end
          MODE_MEAN: begin
            stopped_nxt = mean_stop;
            if (s_r == '0) begin
              res_nxt[0] = '{CMD_MOVE, x_r, y_shift};
              slot_k     = 2'd1;
            end
            if (mean_hit) begin
              sum_nxt = sum_add;
              if (range_last) begin
                res_nxt[slot_k[0]] = '{CMD_LINE, col_r[X_W-1:0], '0};
                mean_slot_nxt      = slot_k[0];
                slot_k             = slot_k + 2'd1;
                mean_go            = 1'b1;
              end
            end
            if (frame_end && slot_k < 2'd2) begin
              res_nxt[slot_k[0]] = '{CMD_LINE, x_r, y_shift};
              slot_k             = slot_k + 2'd1;
            end
          end
          MODE_MINMAX: begin
            if (in_range) begin
              min_nxt = min_new;
              max_nxt = max_new;
              if (range_last) begin
                res_nxt[0] = '{CMD_MOVE, col_r[X_W-1:0], {min_new, {FRAC_W{1'b0}}}};
                res_nxt[1] = '{CMD_LINE, col_r[X_W-1:0], {max_new, {FRAC_W{1'b0}}}};
                slot_k     = 2'd2;
                min_nxt    = '1;
                max_nxt    = '0;
                adv_go     = 1'b1;
              end
            end
          end
          default: begin
            slot_k = 2'd0;
          end
        endcase
        res_cnt_nxt = slot_k;
        priority if (mean_go) begin
          state_nxt = S_MEANGO;
        end else if (adv_go && !frame_end) begin
          state_nxt = S_ADV;
        end else if (slot_k != 2'd0) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
        if (frame_end) begin
          clr = 1'b1;
        end
      end
      S_MEANGO: begin
        sum_nxt   = '0;
        state_nxt = S_MEANW;
      end
      S_MEANW: begin
        if (div_stat.done) begin
          res_nxt[mean_slot_r].y_pos = YPOS_W'(div_quo);
          state_nxt                  = S_ADV;
        end
      end
      S_ADV: begin
        rem_nxt   = rem_carry ? WW'(rem_sum - {1'b0, w_eff}) : rem_sum[WW-1:0];
        rs_nxt    = re_r + RW'(rem_carry);
        col_nxt   = col_r + ((mode_r == MODE_MEAN) ? CW'(MEAN_STRIDE) : CW'(1));
        state_nxt = S_ADV2;
      end
      S_ADV2: begin
        re_nxt    = rs_r + len_cur;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_acc) begin
          if (out_last) begin
            res_idx_nxt = 1'b0;
            state_nxt   = S_IDLE;
          end else begin
            res_idx_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_SETQ;
      end
    endcase

    if (clr) begin
      s_nxt       = '0;
      col_nxt     = '0;
      rs_nxt      = '0;
      re_nxt      = clr_len;
      rem_nxt     = '0;
      min_nxt     = '1;
      max_nxt     = '0;
      sum_nxt     = '0;
      stopped_nxt = 1'b0;
    end

    // any write restarts the frame through the setup divisions
    if (cfg_we) begin
      priority if (cfg_index == CFG_TOTAL_POINTS) begin
        total_points_nxt = cfg_data[NW-1:0];
      end else if (cfg_index == CFG_COLUMN_COUNT) begin
        column_count_nxt = cfg_data[WW-1:0];
      end
      res_idx_nxt = 1'b0;
      state_nxt   = S_SETQ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_SETQ;
      total_points_r <= NW'(1);
      column_count_r <= WW'(1);
      res_idx_r      <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      total_points_r <= total_points_nxt;
      column_count_r <= column_count_nxt;
      res_idx_r      <= res_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r         <= q_nxt;
    r_r         <= r_nxt;
    p_r         <= p_nxt;
    pr_r        <= pr_nxt;
    mode_r      <= mode_nxt;
    s_r         <= s_nxt;
    col_r       <= col_nxt;
    rs_r        <= rs_nxt;
    re_r        <= re_nxt;
    rem_r       <= rem_nxt;
    min_r       <= min_nxt;
    max_r       <= max_nxt;
    sum_r       <= sum_nxt;
    stopped_r   <= stopped_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    res_r       <= res_nxt;
    res_cnt_r   <= res_cnt_nxt;
    mean_slot_r <= mean_slot_nxt;
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = (state_r == S_EMIT);
  assign out_ch.command = res_r[res_idx_r].command;
  assign out_ch.x_pos   = res_r[res_idx_r].x_pos;
  assign out_ch.y_pos   = res_r[res_idx_r].y_pos;
  assign out_ch.last    = out_last;

endmodule

@@ hdl/wdd_checker.sv @@
module wdd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last,
  input logic cfg_we
);

  // stalled transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !cfg_we |=> out_valid)
    else $error("output transaction dropped while stalled");

  // one point at a time: no intake while commands are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a command is pending");

  a_take_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transaction");

  a_cfg_setup: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input ready right after a config write");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("command offered after the last one of a point");

endmodule

bind waveform_display_decimator wdd_checker u_wdd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last),
  .cfg_we    (cfg_we)
);
